// ----- hw/rtl/ctime_date_line_to_epoch_top_macros.svh -----
// Assertion macros shared by the date-line to epoch RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef CTIME_DATE_LINE_TO_EPOCH_TOP_MACROS_SVH
`define CTIME_DATE_LINE_TO_EPOCH_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CDTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CDTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cdte_pkg.sv -----
// Shared types, constants and lookup functions for the date-line to epoch block.
// Used by the interfaces, the front parser, the queue, the back calculator and the top.
`default_nettype none

package cdte_pkg;

    localparam int CHAR_W  = 8;
    localparam int ACC_W   = 17;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int ZONE_W  = 17;
    localparam int EPOCH_W = 39;
    localparam int HMS_W   = 17;
    localparam int DOY_W   = 9;

    localparam int DEFAULT_MAX_YEAR    = 9999;
    localparam int DEFAULT_QUEUE_DEPTH = 2;
    localparam int YEAR_MIN            = 1970;

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact below 43690
    localparam int DIV100_MUL      = 10486;
    localparam int DIV100_SHIFT    = 20;
    localparam int EPOCH_DAY_SHIFT = 719468;
    localparam int SECS_PER_DAY    = 86400;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MIN    = 60;
    localparam int DAYS_PER_YEAR   = 365;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [11:0][23:0] MONTH_NAMES = {
        "Dec", "Nov", "Oct", "Sep", "Aug", "Jul",
        "Jun", "May", "Apr", "Mar", "Feb", "Jan"
    };

    typedef struct packed {
        logic                ok;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
    } date_rec_t;

    typedef struct packed {
        logic      push;
        date_rec_t rec;
    } q_wr_t;

    typedef struct packed {
        logic      valid;
        date_rec_t rec;
    } q_rd_t;

    // months whose name has character c at position pos (position 3 is the space)
    function automatic logic [11:0] month_match(logic [2:0] pos, logic [CHAR_W-1:0] c);
        logic [11:0]       hit;
        logic [CHAR_W-1:0] want;
        hit = '0;
        for (int i = 0; i < 12; i++)
        begin
            case (pos)
                3'd0:    want = MONTH_NAMES[i][23:16];
                3'd1:    want = MONTH_NAMES[i][15:8];
                3'd2:    want = MONTH_NAMES[i][7:0];
                default: want = CH_SPACE;
            endcase
            hit[i] = (c == want);
        end
        return hit;
    endfunction

    // day offset of a month in a March-based year
    function automatic logic [DOY_W-1:0] month_start_day(logic [MONTH_W-1:0] mp);
        logic [DOY_W-1:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cdte_char_if.sv -----
// Character channel: one byte of the line per transfer.
// Depends on cdte_pkg for the field width.
`default_nettype none

interface cdte_char_if;
    logic                         valid;
    logic                         ready;
    logic [cdte_pkg::CHAR_W-1:0]  char_code;
    logic                         end_of_line;

    modport source (output valid, char_code, end_of_line, input ready);
    modport sink   (input valid, char_code, end_of_line, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cdte_date_if.sv -----
// Result channel: one converted date per transfer.
// Depends on cdte_pkg for the field width.
`default_nettype none

interface cdte_date_if;
    logic                                valid;
    logic                                ready;
    logic                                date_valid;
    logic signed [cdte_pkg::EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, date_valid, epoch_seconds, input ready);
    modport sink   (input valid, date_valid, epoch_seconds, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cdte_front.sv -----
// Front parser: takes line characters, tracks the date fields, emits one record per line.
// Depends on cdte_pkg, cdte_char_if and the assertion macro header.
`default_nettype none
`include "ctime_date_line_to_epoch_top_macros.svh"

module cdte_front #(
    parameter int MAX_YEAR = cdte_pkg::DEFAULT_MAX_YEAR
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    cdte_char_if.sink            chars,
    input  wire logic            q_full,
    output cdte_pkg::q_wr_t      q_wr
);

    localparam int ACC_W = cdte_pkg::ACC_W;
    localparam logic [ACC_W-1:0] ACC_SAT  = ACC_W'(MAX_YEAR + 1);
    localparam logic [ACC_W-1:0] YEAR_LO  = ACC_W'(cdte_pkg::YEAR_MIN);
    localparam logic [ACC_W-1:0] YEAR_HI  = ACC_W'(MAX_YEAR);
    localparam logic [ACC_W-1:0] DAY_LO   = ACC_W'(1);
    localparam logic [ACC_W-1:0] DAY_HI   = ACC_W'(31);
    localparam logic [ACC_W-1:0] ZERO_LO  = ACC_W'(0);
    localparam logic [ACC_W-1:0] HOUR_HI  = ACC_W'(23);
    localparam logic [ACC_W-1:0] MINSEC_HI = ACC_W'(59);

    typedef enum logic [3:0] {
        PH_FIRST_SPACE,
        PH_SECOND_SPACE,
        PH_LEAD_SPACES,
        PH_WEEKDAY,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MINUTE,
        PH_SECOND,
        PH_YEAR
    } phase_t;

    typedef struct packed {
        logic             started;
        logic             neg;
        logic             stop;
        logic [ACC_W-1:0] acc;
    } num_t;

    function automatic num_t feed(num_t n, logic [cdte_pkg::CHAR_W-1:0] c);
        num_t       r;
        logic       ws;
        logic [ACC_W-1:0] sum;
        r   = n;
        ws  = (c inside {cdte_pkg::CH_SPACE, [cdte_pkg::CH_TAB:cdte_pkg::CH_CR]});
        sum = n.acc * ACC_W'(10) + ACC_W'(c - cdte_pkg::CH_ZERO);
        if (!n.stop)
        begin
            if (c inside {[cdte_pkg::CH_ZERO:cdte_pkg::CH_NINE]})
            begin
                r.started = 1'b1;
                r.acc     = (sum > ACC_SAT) ? ACC_SAT : sum;
            end
            else if (!n.started && ws)
            begin
                r = n;
            end
            else if (!n.started && (c == cdte_pkg::CH_PLUS || c == cdte_pkg::CH_MINUS))
            begin
                r.started = 1'b1;
                r.neg     = (c == cdte_pkg::CH_MINUS);
            end
            else
            begin
                r.stop = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic take_fail(num_t n, logic [ACC_W-1:0] lo, logic [ACC_W-1:0] hi);
        return (n.neg && n.acc != '0) || n.acc < lo || n.acc > hi;
    endfunction

    phase_t                          phase_reg, phase_next;
    logic [2:0]                      cnt_reg, cnt_next;
    num_t                            num_reg, num_next, num_fed;
    logic [11:0]                     mask_reg, mask_next, mask_upd;
    logic [cdte_pkg::MONTH_W-1:0]    month_reg, month_next, first_month;
    logic [cdte_pkg::DAY_W-1:0]      day_reg, day_next;
    logic [cdte_pkg::HOUR_W-1:0]     hour_reg, hour_next;
    logic [cdte_pkg::MIN_W-1:0]      minute_reg, minute_next;
    logic [cdte_pkg::SEC_W-1:0]      second_reg, second_next;
    logic                            failed_reg, failed_next;
    logic                            in_fire;
    logic [cdte_pkg::CHAR_W-1:0]     c;

    assign chars.ready = !q_full;
    assign in_fire     = chars.valid && chars.ready;
    assign c           = chars.char_code;

    always_comb
    begin
        num_fed     = feed(num_reg, c);
        mask_upd    = mask_reg & cdte_pkg::month_match(cnt_reg, c);
        first_month = '0;
        for (int i = 11; i >= 0; i--)
        begin
            if (mask_upd[i])
            begin
                first_month = cdte_pkg::MONTH_W'(i);
            end
        end

        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        num_next    = num_reg;
        mask_next   = mask_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        failed_next = failed_reg;
        q_wr        = '0;

        if (in_fire)
        begin
            if (!failed_reg)
            begin
                if (c == cdte_pkg::CH_NUL && phase_reg != PH_YEAR)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        PH_FIRST_SPACE:
                        begin
                            if (c == cdte_pkg::CH_SPACE)
                                phase_next = PH_SECOND_SPACE;
                        end
                        PH_SECOND_SPACE:
                        begin
                            if (c == cdte_pkg::CH_SPACE)
                                phase_next = PH_LEAD_SPACES;
                        end
                        PH_LEAD_SPACES:
                        begin
                            if (c != cdte_pkg::CH_SPACE)
                            begin
                                phase_next = PH_WEEKDAY;
                                cnt_next   = 3'd1;
                            end
                        end
                        PH_WEEKDAY:
                        begin
                            if (cnt_reg == 3'd3)
                            begin
                                phase_next = PH_MONTH;
                                cnt_next   = 3'd0;
                                mask_next  = '1;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 3'd1;
                            end
                        end
                        PH_MONTH:
                        begin
                            mask_next = mask_upd;
                            if (cnt_reg == 3'd3)
                            begin
                                if (mask_upd == '0)
                                begin
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    month_next = first_month;
                                    phase_next = PH_DAY;
                                    cnt_next   = 3'd0;
                                    num_next   = '0;
                                end
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 3'd1;
                            end
                        end
                        PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND:
                        begin
                            if (cnt_reg == 3'd2)
                            begin
                                case (phase_reg)
                                    PH_DAY:
                                    begin
                                        failed_next = take_fail(num_fed, DAY_LO, DAY_HI);
                                        day_next    = cdte_pkg::DAY_W'(num_fed.acc);
                                        phase_next  = PH_HOUR;
                                    end
                                    PH_HOUR:
                                    begin
                                        failed_next = take_fail(num_fed, ZERO_LO, HOUR_HI);
                                        hour_next   = cdte_pkg::HOUR_W'(num_fed.acc);
                                        phase_next  = PH_MINUTE;
                                    end
                                    PH_MINUTE:
                                    begin
                                        failed_next = take_fail(num_fed, ZERO_LO, MINSEC_HI);
                                        minute_next = cdte_pkg::MIN_W'(num_fed.acc);
                                        phase_next  = PH_SECOND;
                                    end
                                    default:
                                    begin
                                        failed_next = take_fail(num_fed, ZERO_LO, MINSEC_HI);
                                        second_next = cdte_pkg::SEC_W'(num_fed.acc);
                                        phase_next  = PH_YEAR;
                                    end
                                endcase
                                cnt_next = 3'd0;
                                num_next = '0;
                            end
                            else
                            begin
                                num_next = num_fed;
                                cnt_next = cnt_reg + 3'd1;
                            end
                        end
                        default:
                        begin
                            num_next = num_fed;
                        end
                    endcase
                end
            end

            if (chars.end_of_line)
            begin
                q_wr.push       = 1'b1;
                q_wr.rec.ok     = !failed_next && phase_next == PH_YEAR &&
                                  !take_fail(num_next, YEAR_LO, YEAR_HI);
                q_wr.rec.year   = cdte_pkg::YEAR_W'(num_next.acc);
                q_wr.rec.month  = month_next;
                q_wr.rec.day    = day_next;
                q_wr.rec.hour   = hour_next;
                q_wr.rec.minute = minute_next;
                q_wr.rec.second = second_next;

                phase_next  = PH_FIRST_SPACE;
                cnt_next    = '0;
                num_next    = '0;
                mask_next   = '0;
                month_next  = '0;
                day_next    = '0;
                hour_next   = '0;
                minute_next = '0;
                second_next = '0;
                failed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST_SPACE;
            cnt_reg    <= '0;
            num_reg    <= '0;
            mask_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            num_reg    <= num_next;
            mask_reg   <= mask_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            failed_reg <= failed_next;
        end
    end

    `CDTE_ASSERT_NOW(a_acc_saturated, clk, rst_n, 1'b1, num_reg.acc <= ACC_SAT,
        "number accumulator above saturation value")
    `CDTE_ASSERT_NEXT(a_line_cleared, clk, rst_n, in_fire && chars.end_of_line,
        phase_reg == PH_FIRST_SPACE && !failed_reg && num_reg == '0,
        "line state not cleared after end of line")

endmodule

`default_nettype wire

// ----- hw/rtl/cdte_queue.sv -----
// Short record queue between the front parser and the back calculator.
// Depends on cdte_pkg and the assertion macro header.
`default_nettype none
`include "ctime_date_line_to_epoch_top_macros.svh"

module cdte_queue #(
    parameter int DEPTH = cdte_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  cdte_pkg::q_wr_t      q_wr,
    output logic                 q_full,
    output cdte_pkg::q_rd_t      q_rd,
    input  wire logic            q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cdte_pkg::date_rec_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  do_push, do_pop;

    assign q_full    = (count_reg == CNT_FULL);
    assign q_rd.valid = (count_reg != '0);
    assign q_rd.rec   = entry_reg[rd_ptr_reg];
    assign do_push   = q_wr.push && !q_full;
    assign do_pop    = q_pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= q_wr.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CDTE_ASSERT_NOW(a_no_overflow, clk, rst_n, q_wr.push, !q_full,
        "record pushed into a full queue")
    `CDTE_ASSERT_NOW(a_no_underflow, clk, rst_n, q_pop, q_rd.valid,
        "record popped from an empty queue")

endmodule

`default_nettype wire

// ----- hw/rtl/cdte_back.sv -----
// Back calculator: turns a parsed date record into epoch seconds over several steps.
// Depends on cdte_pkg, cdte_date_if and the assertion macro header.
`default_nettype none
`include "ctime_date_line_to_epoch_top_macros.svh"

module cdte_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  cdte_pkg::q_rd_t                         q_rd,
    output logic                                    q_pop,
    input  wire logic signed [cdte_pkg::ZONE_W-1:0] zone,
    cdte_date_if.source                             dates
);

    localparam int YEAR_W = cdte_pkg::YEAR_W;
    localparam int DAYS_W = 22;
    localparam int PROD_W = 38;
    localparam int SUM_W  = cdte_pkg::EPOCH_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DAYS,
        ST_SCALE,
        ST_SUM
    } state_t;

    state_t                          state_reg;
    logic                            ok_reg;
    logic [YEAR_W-1:0]               yy_reg;
    logic [cdte_pkg::DOY_W-1:0]      doy_reg;
    logic [cdte_pkg::HMS_W-1:0]      hms_reg;
    logic [6:0]                      q100_reg;
    logic [DAYS_W-1:0]               d365_reg;
    logic [DAYS_W-1:0]               days_reg;
    logic [PROD_W-1:0]               prod_reg;
    logic                            out_valid_reg;
    logic                            date_valid_reg;
    logic signed [cdte_pkg::EPOCH_W-1:0] epoch_reg;

    logic [cdte_pkg::MONTH_W-1:0]    mp;
    logic [27:0]                     div_prod;
    logic [DAYS_W:0]                 day_sum;
    logic signed [SUM_W-1:0]         sec_sum;
    logic                            out_free;

    assign q_pop    = (state_reg == ST_IDLE) && q_rd.valid;
    assign out_free = !out_valid_reg || dates.ready;

    assign dates.valid         = out_valid_reg;
    assign dates.date_valid    = date_valid_reg;
    assign dates.epoch_seconds = epoch_reg;

    always_comb
    begin
        mp = (q_rd.rec.month >= 4'd2) ? q_rd.rec.month - 4'd2 : q_rd.rec.month + 4'd10;
        div_prod = 28'(yy_reg) * 28'(cdte_pkg::DIV100_MUL);
        day_sum  = (DAYS_W + 1)'(d365_reg) + (DAYS_W + 1)'(yy_reg >> 2)
                 + (DAYS_W + 1)'(q100_reg >> 2) - (DAYS_W + 1)'(q100_reg)
                 - (DAYS_W + 1)'(cdte_pkg::EPOCH_DAY_SHIFT);
        sec_sum  = $signed({2'b00, prod_reg}) + $signed(SUM_W'(hms_reg))
                 - SUM_W'(zone);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            date_valid_reg <= 1'b0;
            epoch_reg      <= '0;
            ok_reg         <= 1'b0;
            yy_reg         <= '0;
            doy_reg        <= '0;
            hms_reg        <= '0;
            q100_reg       <= '0;
            d365_reg       <= '0;
            days_reg       <= '0;
            prod_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && dates.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_rd.valid)
                    begin
                        ok_reg  <= q_rd.rec.ok;
                        yy_reg  <= (q_rd.rec.month <= 4'd1) ? q_rd.rec.year - YEAR_W'(1)
                                                            : q_rd.rec.year;
                        doy_reg <= cdte_pkg::month_start_day(mp)
                                 + cdte_pkg::DOY_W'(q_rd.rec.day) - cdte_pkg::DOY_W'(1);
                        hms_reg <= cdte_pkg::HMS_W'(q_rd.rec.hour)
                                     * cdte_pkg::HMS_W'(cdte_pkg::SECS_PER_HOUR)
                                 + cdte_pkg::HMS_W'(q_rd.rec.minute)
                                     * cdte_pkg::HMS_W'(cdte_pkg::SECS_PER_MIN)
                                 + cdte_pkg::HMS_W'(q_rd.rec.second);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    q100_reg  <= 7'(div_prod >> cdte_pkg::DIV100_SHIFT);
                    d365_reg  <= DAYS_W'(yy_reg) * DAYS_W'(cdte_pkg::DAYS_PER_YEAR)
                               + DAYS_W'(doy_reg);
                    state_reg <= ST_DAYS;
                end
                ST_DAYS:
                begin
                    days_reg  <= DAYS_W'(day_sum);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    prod_reg  <= PROD_W'(days_reg) * PROD_W'(cdte_pkg::SECS_PER_DAY);
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        date_valid_reg <= ok_reg;
                        epoch_reg      <= ok_reg ? cdte_pkg::EPOCH_W'(sec_sum) : '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `CDTE_ASSERT_NOW(a_invalid_is_zero, clk, rst_n, out_valid_reg && !date_valid_reg,
        epoch_reg == '0, "invalid result carries nonzero seconds")
    `CDTE_ASSERT_NEXT(a_result_held, clk, rst_n,
        state_reg == ST_SUM && out_valid_reg && !dates.ready,
        state_reg == ST_SUM, "finished result overwrote a pending one")

endmodule

`default_nettype wire

// ----- hw/rtl/ctime_date_line_to_epoch_top.sv -----
// Date-line to epoch converter, top level.
// Channels: chars (one byte of a mail From line per transfer, end_of_line on the
//   last byte) and dates (one result per line: date_valid and epoch_seconds).
// Configuration: cfg_wr_en/cfg_wr_data write the signed zone offset in seconds,
//   subtracted from every valid result; write it only while no line is in flight.
// Throughput: one character per cycle while the record queue is not full, set by the
//   front parser; the back calculator takes each line through its steps (divide
//   step, day sum, scale by seconds per day, final sum) before it pops the next record.
// Result path: the last byte's record is written into the queue, popped by the idle
//   back calculator, taken through its steps and registered on dates once output is free.
// A record queue of QUEUE_DEPTH entries (two by default) parts the parser from the
//   calculator; when dates stalls, the finished result holds, the calculator waits,
//   and chars keeps transferring until the queue fills, then ready drops.
// Reset clears the parse state, the queue, the output and the zone offset (0).
// Depends on cdte_pkg, the channel interfaces, cdte_front, cdte_queue, cdte_back.
`default_nettype none

module ctime_date_line_to_epoch_top #(
    parameter int MAX_YEAR    = cdte_pkg::DEFAULT_MAX_YEAR,
    parameter int QUEUE_DEPTH = cdte_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    cdte_char_if.sink                               chars,
    cdte_date_if.source                             dates,
    input  wire logic                               cfg_wr_en,
    input  wire logic signed [cdte_pkg::ZONE_W-1:0] cfg_wr_data
);

    logic signed [cdte_pkg::ZONE_W-1:0] zone_reg;
    cdte_pkg::q_wr_t                    q_wr;
    cdte_pkg::q_rd_t                    q_rd;
    logic                               q_full;
    logic                               q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zone_reg <= '0;
        else if (cfg_wr_en)
            zone_reg <= cfg_wr_data;
    end

    cdte_front #(
        .MAX_YEAR (MAX_YEAR)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    cdte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_rd   (q_rd),
        .q_pop  (q_pop)
    );

    cdte_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_rd  (q_rd),
        .q_pop (q_pop),
        .zone  (zone_reg),
        .dates (dates)
    );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for ctime_date_line_to_epoch_top: streams mail From lines a byte at a time and
// checks each converted date against an in-bench line parser and calendar predictor.
// Depends on cdte_pkg, cdte_char_if, cdte_date_if and the RTL top level.
`timescale 1ns / 1ps

module testbench;

    import cdte_pkg::*;

    localparam int MAX_YEAR = DEFAULT_MAX_YEAR;

    typedef enum logic [3:0] {
        SEEK_SPACE1, SEEK_SPACE2, SKIP_LEAD, IN_WEEKDAY, IN_MONTH,
        IN_DAY, IN_HOUR, IN_MINUTE, IN_SECOND, IN_YEAR
    } parse_step_e;

    typedef struct {
        bit               date_valid;
        logic [EPOCH_W-1:0] epoch_seconds;
    } date_result_t;

    typedef logic [CHAR_W-1:0] char_line_t[$];

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic signed [ZONE_W-1:0] cfg_wr_data;

    cdte_char_if chars_bus ();
    cdte_date_if dates_bus ();

    ctime_date_line_to_epoch_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars_bus),
        .dates       (dates_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    string month_abbr[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                              "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
    string day_names[7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};

    // line parser state
    parse_step_e p_step;
    int          field_pos;
    logic [11:0] month_mask;
    int          num_mag;
    bit          num_started;
    bit          num_neg;
    bit          num_stop;
    int          p_month;
    int          p_day;
    int          p_hour;
    int          p_minute;
    int          p_second;
    int          p_year;
    bit          line_bad;
    logic signed [ZONE_W-1:0] zone_reg;

    date_result_t pending_dates[$];

    bit idle_on;
    int hold_cycles;
    int errors;
    int chars_sent;
    int lines_sent;
    int dates_checked;
    int valid_dates;

    function automatic void clear_line();
        p_step = SEEK_SPACE1;
        field_pos = 0;
        month_mask = '0;
        num_mag = 0;
        num_started = 0;
        num_neg = 0;
        num_stop = 0;
        p_month = 0;
        p_day = 0;
        p_hour = 0;
        p_minute = 0;
        p_second = 0;
        p_year = 0;
        line_bad = 0;
    endfunction

    function automatic void begin_slot(parse_step_e nxt);
        p_step = nxt;
        field_pos = 0;
        num_mag = 0;
        num_started = 0;
        num_neg = 0;
        num_stop = 0;
    endfunction

    function automatic void atoi_feed(logic [CHAR_W-1:0] c);
        bit ws;
        ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        if (num_stop)
            return;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            num_started = 1;
            num_mag = num_mag * 10 + (int'(c) - int'(CH_ZERO));
            if (num_mag > MAX_YEAR + 1)
                num_mag = MAX_YEAR + 1;
        end
        else if (!num_started && ws)
        begin
        end
        else if (!num_started && (c == CH_PLUS || c == CH_MINUS))
        begin
            num_started = 1;
            num_neg = (c == CH_MINUS);
        end
        else
            num_stop = 1;
    endfunction

    function automatic int slot_value(int lo, int hi);
        if ((num_neg && num_mag != 0) || num_mag < lo || num_mag > hi)
        begin
            line_bad = 1;
            return 0;
        end
        return num_mag;
    endfunction

    function automatic void parse_char(logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] want;
        if (line_bad)
            return;
        if (c == CH_NUL && p_step != IN_YEAR)
        begin
            line_bad = 1;
            return;
        end
        case (p_step)
            SEEK_SPACE1:
                if (c == CH_SPACE)
                    p_step = SEEK_SPACE2;
            SEEK_SPACE2:
                if (c == CH_SPACE)
                    p_step = SKIP_LEAD;
            SKIP_LEAD:
                if (c != CH_SPACE)
                begin
                    p_step = IN_WEEKDAY;
                    field_pos = 1;
                end
            IN_WEEKDAY:
            begin
                field_pos++;
                if (field_pos >= 4)
                begin
                    p_step = IN_MONTH;
                    field_pos = 0;
                    month_mask = 12'hFFF;
                end
            end
            IN_MONTH:
            begin
                for (int i = 0; i < 12; i++)
                begin
                    want = (field_pos < 3) ? month_abbr[i][field_pos] : CH_SPACE;
                    if (c != want)
                        month_mask[i] = 1'b0;
                end
                field_pos++;
                if (field_pos >= 4)
                begin
                    if (month_mask == '0)
                        line_bad = 1;
                    else
                    begin
                        for (int i = 11; i >= 0; i--)
                            if (month_mask[i])
                                p_month = i;
                        begin_slot(IN_DAY);
                    end
                end
            end
            IN_DAY, IN_HOUR, IN_MINUTE, IN_SECOND:
            begin
                atoi_feed(c);
                field_pos++;
                if (field_pos >= 3)
                begin
                    case (p_step)
                        IN_DAY:    p_day = slot_value(1, 31);
                        IN_HOUR:   p_hour = slot_value(0, 23);
                        IN_MINUTE: p_minute = slot_value(0, 59);
                        default:   p_second = slot_value(0, 59);
                    endcase
                    begin_slot(parse_step_e'(p_step + 1));
                end
            end
            default:
                atoi_feed(c);
        endcase
    endfunction

    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int leaps_through(int y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    // day number from 1970-01-01; days past the month end simply carry on
    function automatic longint day_count(int y, int m0, int d);
        int cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        longint n;
        n = longint'(365) * (y - 1970) + leaps_through(y - 1) - leaps_through(1969)
            + cum_days[m0] + d - 1;
        if (m0 > 1 && is_leap(y))
            n++;
        return n;
    endfunction

    function automatic date_result_t close_line();
        date_result_t r;
        longint secs;
        r.date_valid = !line_bad && p_step == IN_YEAR;
        r.epoch_seconds = '0;
        if (r.date_valid)
        begin
            p_year = slot_value(1970, MAX_YEAR);
            r.date_valid = !line_bad;
        end
        if (r.date_valid)
        begin
            secs = day_count(p_year, p_month, p_day) * 86400 + longint'(p_hour) * 3600
                 + p_minute * 60 + p_second - longint'(zone_reg);
            r.epoch_seconds = secs[EPOCH_W-1:0];
        end
        clear_line();
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result sink: random stalls, plus long holds requested by a test
    initial
    begin
        int burst;
        burst = 0;
        dates_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                dates_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else if (burst > 0)
            begin
                dates_bus.ready <= 1'b0;
                burst--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                dates_bus.ready <= 1'b0;
                burst = $urandom_range(1, 12) - 1;
            end
            else
                dates_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        date_result_t want;
        if (rst_n && dates_bus.valid && dates_bus.ready)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("date transfer with none pending: date_valid %0d epoch_seconds %0d",
                       dates_bus.date_valid, dates_bus.epoch_seconds);
                errors++;
            end
            else
            begin
                want = pending_dates.pop_front();
                dates_checked++;
                if (want.date_valid)
                    valid_dates++;
                if (dates_bus.date_valid !== want.date_valid)
                begin
                    $error("date_valid: expected %0d, got %0d",
                           want.date_valid, dates_bus.date_valid);
                    errors++;
                end
                if (dates_bus.epoch_seconds !== want.epoch_seconds)
                begin
                    $error("epoch_seconds: expected %0d, got %0d",
                           $signed(want.epoch_seconds), dates_bus.epoch_seconds);
                    errors++;
                end
            end
        end
    end

    task automatic send_char(logic [CHAR_W-1:0] c, bit eol);
        date_result_t r;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            chars_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        chars_bus.valid <= 1'b1;
        chars_bus.char_code <= c;
        chars_bus.end_of_line <= eol;
        @(posedge clk);
        while (!chars_bus.ready)
            @(posedge clk);
        chars_sent++;
        parse_char(c);
        if (eol)
        begin
            r = close_line();
            pending_dates.push_back(r);
            lines_sent++;
        end
        @(negedge clk);
    endtask

    task automatic send_line(char_line_t l);
        foreach (l[i])
            send_char(l[i], i == l.size() - 1);
    endtask

    task automatic add_text(ref char_line_t l, input string s);
        for (int i = 0; i < s.len(); i++)
            l.push_back(s[i]);
    endtask

    task automatic send_text(string s);
        char_line_t l;
        l = {};
        add_text(l, s);
        send_line(l);
    endtask

    // drop valid, wait for every pending date, then settle
    task automatic drain_dates(int settle);
        chars_bus.valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_zone(logic signed [ZONE_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        zone_reg = v;
    endtask

    task automatic make_random_line(output char_line_t l);
        int kind;
        int d;
        int h;
        int mi;
        int s;
        int y;
        l = {};
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 40)) l.push_back(8'($urandom_range(0, 255)));
            return;
        end
        d = $urandom_range(1, 31);
        h = $urandom_range(0, 23);
        mi = $urandom_range(0, 59);
        s = $urandom_range(0, 59);
        y = ($urandom_range(0, 3) == 0) ? $urandom_range(1970, MAX_YEAR)
                                        : $urandom_range(1970, 2106);
        if (kind >= 80 && kind < 92)
            case ($urandom_range(0, 4))
                0:       d = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
                1:       h = $urandom_range(24, 99);
                2:       mi = $urandom_range(60, 99);
                3:       s = $urandom_range(60, 99);
                default: y = $urandom_range(0, 1) ? $urandom_range(0, 1969)
                                                  : $urandom_range(MAX_YEAR + 1, 99999);
            endcase
        add_text(l, "From ");
        repeat ($urandom_range(1, 8)) l.push_back(8'($urandom_range(33, 126)));
        add_text(l, " ");
        repeat ($urandom_range(0, 2)) add_text(l, " ");
        if ($urandom_range(0, 7) == 0)
            repeat (3) l.push_back(8'($urandom_range(33, 126)));
        else
            add_text(l, day_names[$urandom_range(0, 6)]);
        add_text(l, " ");
        add_text(l, month_abbr[$urandom_range(0, 11)]);
        add_text(l, " ");
        case ($urandom_range(0, 3))
            0:       add_text(l, $sformatf("%2d ", d));
            1:       add_text(l, $sformatf("%02d ", d));
            2:       add_text(l, (d < 10) ? $sformatf("+%0d ", d) : $sformatf("+%0d", d));
            default: add_text(l, (d < 10) ? $sformatf("\t%0d ", d) : $sformatf("%0d\t", d));
        endcase
        add_text(l, $sformatf("%02d:%02d:%02d ", h, mi, s));
        add_text(l, ($urandom_range(0, 7) == 0) ? $sformatf("00%0d", y) : $sformatf("%0d", y));
        if ($urandom_range(0, 3) == 0)
            add_text(l, " remote from relay");
        if (kind >= 60 && kind < 70)
            l[$urandom_range(0, l.size() - 1)] = 8'($urandom_range(1, 255));
        else if (kind >= 70 && kind < 80)
            l = l[0 : $urandom_range(0, l.size() - 2)];
        else if (kind >= 92)
            l.insert($urandom_range(0, l.size() - 1), CH_NUL);
    endtask

    task automatic test_directed_lines();
        char_line_t l;
        send_text("From MAILER-DAEMON Thu Jan  1 00:00:00 1970");
        send_text("From x Fri Dec 31 23:59:59 9999");
        send_text("From someone Mon");
        send_text("X");
        l = {};
        add_text(l, "From a b Mo");
        l.push_back(CH_NUL);
        add_text(l, "n Jan  1 00:00:00 1970");
        send_line(l);
        l = {};
        add_text(l, "  Sat Jul  4 12:34:56 2024");
        l.push_back(CH_NUL);
        add_text(l, "99");
        send_line(l);
        send_text("  Sun Mar 1 2 3 4 5 6 2001");
        send_text("  Tue Apr +5 -0:+1:-0 1999");
        send_text("  Tue Apr  5 -1:00:00 1999");
        send_text("  Wed May  6 07:08:09 123456");
        send_text("  Wed May  6 07:08:09 0000002030");
        send_text("From a@b Thu Jun 30 01:02:03 2010 remote from host");
        send_text("  Fri Feb 31 12:00:00 2023");
        send_text("  Tue Feb 29 00:00:00 2000");
        send_text("  Sat Jan  0 00:00:00 2000");
        send_text("  Sat Jan 32 00:00:00 2000");
        send_text("  Sat Jan  1 24:00:00 2000");
        send_text("  Sat Jan  1 10:60:00 2000");
        send_text("  Sat Jan  1 10:00:60 2000");
        send_text("  Wed Dec 31 23:59:59 1969");
        send_text("  Sat Jan  1 00:00:00 10000");
        send_text("  Sun jan 01 00:00:00 2000");
        send_text("  Sun Jan-01 00:00:00 2000");
        send_text("  Mon Aug \t9\t10:11:12\t2222");
    endtask

    task automatic test_zone_offsets();
        logic signed [ZONE_W-1:0] zones[5];
        zones = '{-17'sd50400, 17'sd50400, -17'sd65536, 17'sd65535, 17'sd0};
        foreach (zones[i])
        begin
            drain_dates(10);
            apply_zone(zones[i]);
            send_text("From MAILER-DAEMON Thu Jan  1 00:00:00 1970");
            send_text("From x Fri Dec 31 23:59:59 9999");
            send_text("From y Sun Jun 15 13:45:30 2031");
        end
    endtask

    task automatic test_random_lines(int n_chars, int n_lines);
        char_line_t l;
        int c0;
        int l0;
        c0 = chars_sent;
        l0 = lines_sent;
        while (chars_sent - c0 < n_chars || lines_sent - l0 < n_lines)
        begin
            make_random_line(l);
            send_line(l);
        end
    endtask

    // hold dates off long enough that the record queue fills and chars stalls
    task automatic test_output_stall();
        hold_cycles = 300;
        repeat (12) send_text("X");
        send_text("From p Mon Oct 12 08:30:00 2015");
        send_text("  Sun Mar  8 02:00:00 2020");
        drain_dates(0);
    endtask

    task automatic test_sender_pause();
        send_text("From q Tue Nov  1 11:11:11 2011");
        send_text("From r Wed Nov  2 22:22:22 2022");
        drain_dates(0);
        send_text("From s Thu Nov  3 03:33:33 2033");
        drain_dates(0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        chars_bus.valid = 1'b0;
        chars_bus.char_code = '0;
        chars_bus.end_of_line = 1'b0;
        idle_on = 1;
        hold_cycles = 0;
        errors = 0;
        chars_sent = 0;
        lines_sent = 0;
        dates_checked = 0;
        valid_dates = 0;
        zone_reg = '0;
        clear_line();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_lines();
        test_zone_offsets();
        drain_dates(10);
        apply_zone(ZONE_W'($urandom_range(0, 100800) - 50400));
        test_random_lines(250, 20);
        test_output_stall();
        test_sender_pause();
        drain_dates(10);
        apply_zone(ZONE_W'($urandom_range(0, 100800) - 50400));
        test_random_lines(250, 20);
        drain_dates(10);
        idle_on = 0;
        apply_zone(ZONE_W'($urandom_range(0, 100800) - 50400));
        test_random_lines(250, 20);

        drain_dates(20);
        $display("Checked %0d dates (%0d valid) from %0d characters in %0d lines.",
                 dates_checked, valid_dates, chars_sent, lines_sent);
        $display("Zone offsets spanned both register extremes; long output hold and full rate.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/cdte_pkg.sv
hw/rtl/cdte_char_if.sv
hw/rtl/cdte_date_if.sv
hw/rtl/cdte_front.sv
hw/rtl/cdte_queue.sv
hw/rtl/cdte_back.sv
hw/rtl/ctime_date_line_to_epoch_top.sv
tb/sv/testbench.sv
